// ===== design/double_ended_queue_macros.svh =====
// Assertion macros for the deque RTL.
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// Check that cons holds in the same cycle whenever ante holds.
`define DQE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("deque check failed in the same cycle");

// Check that cons holds in the cycle after ante.
`define DQE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("deque check failed one cycle later");

`endif

// ===== design/dqe_pkg.sv =====
package dqe_pkg;

  // Default sizes
  localparam int unsigned DepthDef = 16;
  localparam int unsigned DataWidthDef = 32;

  // Fixed field widths of the stream payloads
  localparam int unsigned ModeW = 3;
  localparam int unsigned ValueW = 32;
  localparam int unsigned CountW = 5;
  localparam int unsigned ErrW = 2;
  localparam int unsigned OutDataW = 104;

  typedef enum logic [ModeW-1:0] {
    MODE_QUERY      = 3'd0,
    MODE_PUSH_FRONT = 3'd1,
    MODE_PUSH_BACK  = 3'd2,
    MODE_POP_FRONT  = 3'd3,
    MODE_POP_BACK   = 3'd4,
    MODE_CLEAR      = 3'd5
  } mode_e;

  typedef enum logic [ErrW-1:0] {
    ERR_OK    = 2'd0,
    ERR_EMPTY = 2'd1,
    ERR_FULL  = 2'd2
  } err_e;

  // Per-cycle command broadcast to every cell of one chain
  typedef struct packed {
    logic shift_in;   // insert new word at the head, everything moves one cell back
    logic shift_out;  // remove the head word, everything moves one cell forward
    logic append;     // write new word into the first free cell
    logic drop;       // free the last occupied cell
    logic clear;      // free every cell
  } cell_op_t;

endpackage

// ===== design/dqe_cell.sv =====
module dqe_cell #(
  parameter int unsigned DATA_WIDTH = dqe_pkg::DataWidthDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dqe_pkg::cell_op_t     op_i,
  input  logic [DATA_WIDTH-1:0] new_word_i,
  input  logic                  prev_valid_i,
  input  logic [DATA_WIDTH-1:0] prev_word_i,
  input  logic                  next_valid_i,
  input  logic [DATA_WIDTH-1:0] next_word_i,
  output logic                  valid_o,
  output logic [DATA_WIDTH-1:0] word_o
);

  logic                  valid_q, valid_d;
  logic [DATA_WIDTH-1:0] word_q, word_d;
  logic                  is_free_slot;
  logic                  is_tail;

  assign is_free_slot = !valid_q && prev_valid_i;
  assign is_tail      = valid_q && !next_valid_i;

  // Pick next content from the broadcast command and the neighbors
  always_comb begin
    valid_d = valid_q;
    word_d  = word_q;
    if (op_i.clear) begin
      valid_d = 1'b0;
    end else if (op_i.shift_in) begin
      valid_d = prev_valid_i;
      word_d  = prev_word_i;
    end else if (op_i.shift_out) begin
      valid_d = next_valid_i;
      word_d  = next_word_i;
    end else if (op_i.append && is_free_slot) begin
      valid_d = 1'b1;
      word_d  = new_word_i;
    end else if (op_i.drop && is_tail) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

// ===== design/dqe_chain.sv =====
module dqe_chain #(
  parameter int unsigned DEPTH      = dqe_pkg::DepthDef,
  parameter int unsigned DATA_WIDTH = dqe_pkg::DataWidthDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dqe_pkg::cell_op_t     op_i,
  input  logic [DATA_WIDTH-1:0] new_word_i,
  output logic [DATA_WIDTH-1:0] head_word_o,
  output logic [DATA_WIDTH-1:0] second_word_o,
  output logic [DEPTH-1:0]      valid_o
);

  logic                  valid_w [DEPTH];
  logic [DATA_WIDTH-1:0] word_w  [DEPTH];

  // Row of cells; the head cell sees the new word as its upstream neighbor
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                  prev_valid;
    logic [DATA_WIDTH-1:0] prev_word;
    logic                  next_valid;
    logic [DATA_WIDTH-1:0] next_word;

    if (i == 0) begin : g_head
      assign prev_valid = 1'b1;
      assign prev_word  = new_word_i;
    end else begin : g_body
      assign prev_valid = valid_w[i-1];
      assign prev_word  = word_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_valid = 1'b0;
      assign next_word  = '0;
    end else begin : g_inner
      assign next_valid = valid_w[i+1];
      assign next_word  = word_w[i+1];
    end

    dqe_cell #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .op_i        (op_i),
      .new_word_i  (new_word_i),
      .prev_valid_i(prev_valid),
      .prev_word_i (prev_word),
      .next_valid_i(next_valid),
      .next_word_i (next_word),
      .valid_o     (valid_w[i]),
      .word_o      (word_w[i])
    );

    assign valid_o[i] = valid_w[i];
  end

  assign head_word_o   = word_w[0];
  assign second_word_o = word_w[1];

endmodule

// ===== design/double_ended_queue.sv =====
// Channel  Dir  Handshake              Payload
// s_axis   in   s_axis_tvalid/tready   tuser: mode; tdata: value
// m_axis   out  m_axis_tvalid/tready   tdata: popped, front, back, count, empty, error
//
// One transaction per cycle when the result register is free or being drained;
// each input transaction's result is in the output register in the cycle after it.
// Two rows of DEPTH cells hold the words, one with the front word at its head
// and one with the back word at its head; both update in the same cycle.
// Reset clears the valid bit of every cell, the count and the result valid flag.
// A stalled result holds the input side once the result register is full.
`include "double_ended_queue_macros.svh"

module double_ended_queue #(
  parameter int unsigned DEPTH      = dqe_pkg::DepthDef,
  parameter int unsigned DATA_WIDTH = dqe_pkg::DataWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [dqe_pkg::ValueW-1:0]    s_axis_tdata,   // [31:0] value
  input  logic [dqe_pkg::ModeW-1:0]     s_axis_tuser,   // [2:0] mode
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [31:0] popped_value, [63:32] front_value, [95:64] back_value,
  // [100:96] item_count, [101] is_empty, [103:102] error
  output logic [dqe_pkg::OutDataW-1:0]  m_axis_tdata
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(DEPTH);

  logic                  accept;
  logic                  is_full, is_empty_now;
  logic [DATA_WIDTH-1:0] new_word;
  dqe_pkg::mode_e        mode;
  dqe_pkg::err_e         err;
  dqe_pkg::cell_op_t     front_op, back_op;
  logic [CntW-1:0]       count_q, count_d;
  logic [DATA_WIDTH-1:0] f_head, f_second, b_head, b_second;
  logic [DEPTH-1:0]      f_valid, b_valid;
  logic [DATA_WIDTH-1:0] popped, front_new, back_new;
  logic                  out_valid_q;
  logic [dqe_pkg::OutDataW-1:0] out_data_q, out_data_d;
  logic                  push_dropped;
  logic                  out_full;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign mode          = dqe_pkg::mode_e'(s_axis_tuser);
  assign new_word      = DATA_WIDTH'(s_axis_tdata);
  assign is_full       = count_q == DepthCnt;
  assign is_empty_now  = count_q == '0;

  // Decode the operation into commands for both rows and the new results
  always_comb begin
    front_op  = '0;
    back_op   = '0;
    count_d   = count_q;
    err       = dqe_pkg::ERR_OK;
    popped    = '0;
    front_new = f_head;
    back_new  = b_head;
    case (mode)
      dqe_pkg::MODE_PUSH_FRONT: begin
        if (is_full) begin
          err = dqe_pkg::ERR_FULL;
        end else begin
          front_op.shift_in = 1'b1;
          back_op.append    = 1'b1;
          count_d           = count_q + 1'b1;
          front_new         = new_word;
          if (is_empty_now) begin
            back_new = new_word;
          end
        end
      end
      dqe_pkg::MODE_PUSH_BACK: begin
        if (is_full) begin
          err = dqe_pkg::ERR_FULL;
        end else begin
          back_op.shift_in = 1'b1;
          front_op.append  = 1'b1;
          count_d          = count_q + 1'b1;
          back_new         = new_word;
          if (is_empty_now) begin
            front_new = new_word;
          end
        end
      end
      dqe_pkg::MODE_POP_FRONT: begin
        if (is_empty_now) begin
          err = dqe_pkg::ERR_EMPTY;
        end else begin
          front_op.shift_out = 1'b1;
          back_op.drop       = 1'b1;
          count_d            = count_q - 1'b1;
          popped             = f_head;
          front_new          = f_second;
        end
      end
      dqe_pkg::MODE_POP_BACK: begin
        if (is_empty_now) begin
          err = dqe_pkg::ERR_EMPTY;
        end else begin
          back_op.shift_out = 1'b1;
          front_op.drop     = 1'b1;
          count_d           = count_q - 1'b1;
          popped            = b_head;
          back_new          = b_second;
        end
      end
      dqe_pkg::MODE_CLEAR: begin
        front_op.clear = 1'b1;
        back_op.clear  = 1'b1;
        count_d        = '0;
      end
      default: begin
      end
    endcase
    if (!accept) begin
      front_op = '0;
      back_op  = '0;
    end
  end

  // Pack the result transaction
  always_comb begin
    out_data_d          = '0;
    out_data_d[31:0]    = 32'(popped);
    out_data_d[63:32]   = (count_d == '0) ? 32'd0 : 32'(front_new);
    out_data_d[95:64]   = (count_d == '0) ? 32'd0 : 32'(back_new);
    out_data_d[100:96]  = dqe_pkg::CountW'(count_d);
    out_data_d[101]     = count_d == '0;
    out_data_d[103:102] = err;
  end

  dqe_chain #(
    .DEPTH     (DEPTH),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_front_chain (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .op_i         (front_op),
    .new_word_i   (new_word),
    .head_word_o  (f_head),
    .second_word_o(f_second),
    .valid_o      (f_valid)
  );

  dqe_chain #(
    .DEPTH     (DEPTH),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_back_chain (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .op_i         (back_op),
    .new_word_i   (new_word),
    .head_word_o  (b_head),
    .second_word_o(b_second),
    .valid_o      (b_valid)
  );

  // Advance count and result register on each transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Push taken while full, and a full error in the result register
  assign push_dropped = accept && is_full &&
                        (mode == dqe_pkg::MODE_PUSH_FRONT || mode == dqe_pkg::MODE_PUSH_BACK);
  assign out_full     = out_data_q[103:102] == dqe_pkg::ERR_FULL;

  `DQE_ASSERT_NOW(a_count_range, clk_i, rst_ni, 1'b1, count_q <= DepthCnt)
  `DQE_ASSERT_NOW(a_front_cells, clk_i, rst_ni, 1'b1, $countones(f_valid) == int'(count_q))
  `DQE_ASSERT_NOW(a_back_cells, clk_i, rst_ni, 1'b1, $countones(b_valid) == int'(count_q))
  `DQE_ASSERT_NOW(a_empty_flag, clk_i, rst_ni, out_valid_q, out_data_q[101] == (out_data_q[100:96] == '0))
  `DQE_ASSERT_NEXT(a_full_drop, clk_i, rst_ni, push_dropped, out_full && $stable(count_q))

endmodule
